FILE: hdl/ipv4p_pkg.sv
package ipv4p_pkg;

    localparam int CharW    = 8;
    localparam int ValueW   = 32;
    localparam int CountW   = 3;
    localparam int PartsMax = 4;
    localparam int SlotW    = $clog2(PartsMax);
    localparam int DigitW   = 4;
    localparam int ProdW    = ValueW + DigitW;

    localparam logic [CharW-1:0] CH_NUL   = 8'h00;
    localparam logic [CharW-1:0] CH_DOT   = 8'h2E;
    localparam logic [CharW-1:0] CH_ZERO  = 8'h30;
    localparam logic [CharW-1:0] CH_NINE  = 8'h39;
    localparam logic [CharW-1:0] CH_LO_A  = 8'h61;
    localparam logic [CharW-1:0] CH_LO_F  = 8'h66;
    localparam logic [CharW-1:0] CH_UP_A  = 8'h41;
    localparam logic [CharW-1:0] CH_UP_F  = 8'h46;
    localparam logic [CharW-1:0] CH_LO_X  = 8'h78;
    localparam logic [CharW-1:0] CH_UP_X  = 8'h58;

    localparam logic [DigitW-1:0] OCT_LIMIT   = 4'd8;
    localparam logic [DigitW-1:0] HEX_LETTER  = 4'd9;
    localparam logic [ValueW-1:0] ALL_ONES    = 32'hFFFF_FFFF;

    typedef enum logic [2:0] {
        PH_START  = 3'b001,
        PH_ZERO   = 3'b010,
        PH_DIGITS = 3'b100
    } phase_t;

    typedef enum logic [1:0] {
        RX_DEC = 2'd0,
        RX_OCT = 2'd1,
        RX_HEX = 2'd2
    } radix_t;

    typedef struct packed {
        phase_t              phase;
        radix_t              radix;
        logic                digit_seen;
        logic [ValueW-1:0]   accum;
        logic [CountW-1:0]   parts_done;
        logic                error_seen;
    } scan_state_t;

    typedef struct packed {
        logic                we;
        logic [SlotW-1:0]    idx;
        logic [ValueW-1:0]   data;
    } store_wr_t;

    localparam scan_state_t SCAN_IDLE = '{
        phase:      PH_START,
        radix:      RX_DEC,
        digit_seen: 1'b0,
        accum:      '0,
        parts_done: '0,
        error_seen: 1'b0
    };

endpackage

FILE: hdl/ipv4p_scan.sv
module ipv4p_scan (
    input  ipv4p_pkg::scan_state_t          cur,
    input  logic [ipv4p_pkg::CharW-1:0]     char_byte,
    output ipv4p_pkg::scan_state_t          nxt,
    output ipv4p_pkg::store_wr_t            wr
);
    import ipv4p_pkg::*;

    radix_t              rx_e;
    logic                seen_e;
    logic [ValueW-1:0]   acc_e;
    logic                is_dec;
    logic                is_lo;
    logic                is_up;
    logic [DigitW-1:0]   digit;
    logic                digit_ok;
    logic [ProdW-1:0]    prod;
    logic [ProdW-1:0]    sum;
    logic                overflow;
    logic                finish_ok;

    // radix, seen flag and accumulator as the digit logic must see them this beat
    always_comb
    begin
        acc_e  = (cur.phase == PH_START) ? '0 : cur.accum;
        rx_e   = cur.radix;
        seen_e = cur.digit_seen;
        case (cur.phase)
            PH_START:
            begin
                if (char_byte == CH_ZERO)
                begin
                    rx_e   = RX_OCT;
                    seen_e = 1'b1;
                end
                else
                begin
                    rx_e   = RX_DEC;
                    seen_e = 1'b0;
                end
            end
            PH_ZERO:
            begin
                rx_e   = RX_OCT;
                seen_e = cur.digit_seen;
            end
            default:
            begin
                rx_e   = cur.radix;
                seen_e = cur.digit_seen;
            end
        endcase
    end

    always_comb
    begin
        is_dec = (char_byte >= CH_ZERO) && (char_byte <= CH_NINE);
        is_lo  = (char_byte >= CH_LO_A) && (char_byte <= CH_LO_F);
        is_up  = (char_byte >= CH_UP_A) && (char_byte <= CH_UP_F);
        // letters a-f sit at low nibble 1..6
        digit  = is_dec ? char_byte[DigitW-1:0] : char_byte[DigitW-1:0] + HEX_LETTER;
        case (rx_e)
            RX_OCT:  digit_ok = is_dec && (digit < OCT_LIMIT);
            RX_HEX:  digit_ok = is_dec || is_lo || is_up;
            default: digit_ok = is_dec;
        endcase
        case (rx_e)
            RX_OCT:  prod = {{DigitW{1'b0}}, acc_e} << 3;
            RX_HEX:  prod = {{DigitW{1'b0}}, acc_e} << 4;
            default: prod = ({{DigitW{1'b0}}, acc_e} << 3) + ({{DigitW{1'b0}}, acc_e} << 1);
        endcase
        sum      = prod + {{(ProdW-DigitW){1'b0}}, digit};
        overflow = |sum[ProdW-1:ValueW];
    end

    assign finish_ok = seen_e && (cur.parts_done < CountW'(PartsMax));

    always_comb
    begin
        nxt     = cur;
        wr.we   = 1'b0;
        wr.idx  = cur.parts_done[SlotW-1:0];
        wr.data = acc_e;
        if (cur.error_seen)
        begin
            nxt = cur;
        end
        else if (char_byte == CH_NUL)
        begin
            if (cur.phase == PH_START || !finish_ok)
                nxt.error_seen = 1'b1;
            else
            begin
                wr.we          = 1'b1;
                nxt.parts_done = cur.parts_done + 1'b1;
            end
        end
        else if (cur.phase == PH_START && char_byte == CH_ZERO)
        begin
            nxt.phase      = PH_ZERO;
            nxt.radix      = RX_OCT;
            nxt.digit_seen = 1'b1;
            nxt.accum      = '0;
        end
        else if (cur.phase == PH_ZERO && (char_byte == CH_LO_X || char_byte == CH_UP_X))
        begin
            nxt.phase      = PH_DIGITS;
            nxt.radix      = RX_HEX;
            nxt.digit_seen = 1'b0;
        end
        else
        begin
            nxt.phase      = PH_DIGITS;
            nxt.radix      = rx_e;
            nxt.accum      = acc_e;
            nxt.digit_seen = seen_e;
            if (digit_ok)
            begin
                if (overflow)
                    nxt.error_seen = 1'b1;
                else
                begin
                    nxt.accum      = sum[ValueW-1:0];
                    nxt.digit_seen = 1'b1;
                end
            end
            else if (char_byte == CH_DOT)
            begin
                if (finish_ok)
                begin
                    wr.we          = 1'b1;
                    nxt.parts_done = cur.parts_done + 1'b1;
                    nxt.phase      = PH_START;
                    nxt.radix      = RX_DEC;
                    nxt.digit_seen = 1'b0;
                    nxt.accum      = '0;
                end
                else
                    nxt.error_seen = 1'b1;
            end
            else
                nxt.error_seen = 1'b1;
        end
    end

endmodule

FILE: hdl/ipv4p_pack.sv
module ipv4p_pack (
    input  logic                             mode,
    input  logic [ipv4p_pkg::CountW-1:0]     parts,
    input  logic [ipv4p_pkg::ValueW-1:0]     part [ipv4p_pkg::PartsMax],
    output logic                             ok,
    output logic [ipv4p_pkg::ValueW-1:0]     value
);
    import ipv4p_pkg::*;

    logic [PartsMax-1:0] fits8;
    logic                fits16;
    logic                fits24;

    always_comb
    begin
        for (int i = 0; i < PartsMax; i++)
            fits8[i] = ~|part[i][ValueW-1:8];
        fits16 = ~|part[2][ValueW-1:16];
        fits24 = ~|part[1][ValueW-1:24];
    end

    always_comb
    begin
        ok    = 1'b0;
        value = ALL_ONES;
        case (parts)
            3'd1:
            begin
                if (mode)
                begin
                    ok    = fits8[0];
                    value = {24'd0, part[0][7:0]};
                end
                else
                begin
                    ok    = 1'b1;
                    value = part[0];
                end
            end
            3'd2:
            begin
                if (mode)
                begin
                    ok    = fits8[0] & fits8[1];
                    value = {16'd0, part[0][7:0], part[1][7:0]};
                end
                else
                begin
                    ok    = fits8[0] & fits24;
                    value = {part[0][7:0], part[1][23:0]};
                end
            end
            3'd3:
            begin
                if (mode)
                begin
                    ok    = fits8[0] & fits8[1] & fits8[2];
                    value = {8'd0, part[0][7:0], part[1][7:0], part[2][7:0]};
                end
                else
                begin
                    ok    = fits8[0] & fits8[1] & fits16;
                    value = {part[0][7:0], part[1][7:0], part[2][15:0]};
                end
            end
            3'd4:
            begin
                ok    = &fits8;
                value = {part[0][7:0], part[1][7:0], part[2][7:0], part[3][7:0]};
            end
            default:
            begin
                ok    = 1'b0;
                value = ALL_ONES;
            end
        endcase
    end

endmodule

FILE: hdl/ipv4_address_text_parser_unit.sv
// Parses dotted IPv4 text (decimal, 0-prefixed octal, 0x hex parts, up to four) fed one
// character per beat and ending with a NUL byte. One character is taken every cycle: the
// beat sits in an input register, is scanned against the parse state, and on the NUL beat
// the assembled result lands in the output register as the beat leaves the input register.
// Only a NUL beat meeting a full, stalled output register holds the input side back; all
// other characters keep flowing. result_mode picks address widening (0) or packed network
// bytes (1); the user is to write it only while the block is idle, which is not enforced.
module ipv4_address_text_parser_unit (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             result_mode_wr,
    input  logic                             result_mode,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic [ipv4p_pkg::CharW-1:0]      char_byte,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic                             parse_ok,
    output logic [ipv4p_pkg::ValueW-1:0]     address_value,
    output logic [ipv4p_pkg::CountW-1:0]     part_count
);
    import ipv4p_pkg::*;

    logic                mode_reg;
    logic                in_valid_reg;
    logic [CharW-1:0]    char_reg;
    scan_state_t         state_reg;
    scan_state_t         state_next;
    store_wr_t           wr;
    logic [ValueW-1:0]   store_reg  [PartsMax];
    logic [ValueW-1:0]   store_view [PartsMax];
    logic                out_valid_reg;
    logic                parse_ok_reg;
    logic [ValueW-1:0]   value_reg;
    logic [CountW-1:0]   count_reg;
    logic                is_end;
    logic                proceed;
    logic                fire;
    logic                pack_ok;
    logic [ValueW-1:0]   pack_value;
    logic                good;

    assign is_end   = (char_reg == CH_NUL);
    assign proceed  = !is_end || !out_valid_reg || !out_stall;
    assign fire     = in_valid_reg && proceed;
    assign in_stall = in_valid_reg && !proceed;

    ipv4p_scan u_scan (
        .cur       (state_reg),
        .char_byte (char_reg),
        .nxt       (state_next),
        .wr        (wr)
    );

    // the part closed by the NUL beat is seen before it is stored
    always_comb
    begin
        for (int i = 0; i < PartsMax; i++)
            store_view[i] = (wr.we && wr.idx == SlotW'(i)) ? wr.data : store_reg[i];
    end

    ipv4p_pack u_pack (
        .mode  (mode_reg),
        .parts (state_next.parts_done),
        .part  (store_view),
        .ok    (pack_ok),
        .value (pack_value)
    );

    assign good = pack_ok && !state_next.error_seen;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mode_reg <= 1'b0;
        else if (result_mode_wr)
            mode_reg <= result_mode;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            state_reg     <= SCAN_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= in_stall ? 1'b1 : in_valid;
            if (fire)
                state_reg <= is_end ? SCAN_IDLE : state_next;
            if (fire && is_end)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
            char_reg <= char_byte;
        if (fire && wr.we)
            store_reg[wr.idx] <= wr.data;
        if (fire && is_end)
        begin
            parse_ok_reg <= good;
            value_reg    <= good ? pack_value : ALL_ONES;
            count_reg    <= good ? state_next.parts_done : '0;
        end
    end

    assign out_valid     = out_valid_reg;
    assign parse_ok      = parse_ok_reg;
    assign address_value = value_reg;
    assign part_count    = count_reg;

endmodule

FILE: bench/ipv4_address_text_parser_unit_tb.sv
module ipv4_address_text_parser_unit_tb;
    import ipv4p_pkg::*;

    localparam int BytesPerPhase = 270;
    localparam int CycleLimit    = 400000;
    localparam int HoldCycles    = 300;
    localparam int DrainCycles   = 4;
    localparam int PrintCap      = 50;

    typedef struct packed {
        logic                ok;
        logic [ValueW-1:0]   value;
        logic [CountW-1:0]   count;
    } parse_result_t;

    typedef struct {
        string               text;
        bit                  mode;
        bit                  typed;
        parse_result_t       res;
    } text_case_t;

    localparam parse_result_t FAIL_RES = '{ok: 1'b0, value: ALL_ONES, count: '0};

    logic                clk;
    logic                rst_n;
    logic                result_mode_wr;
    logic                result_mode;
    logic                in_valid;
    logic                in_stall;
    logic [CharW-1:0]    char_byte;
    logic                out_valid;
    logic                out_stall;
    logic                parse_ok;
    logic [ValueW-1:0]   address_value;
    logic [CountW-1:0]   part_count;

    ipv4_address_text_parser_unit uut (
        .clk            (clk),
        .rst_n          (rst_n),
        .result_mode_wr (result_mode_wr),
        .result_mode    (result_mode),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .char_byte      (char_byte),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .parse_ok       (parse_ok),
        .address_value  (address_value),
        .part_count     (part_count)
    );

    // predictor copy of the parse state
    bit                  mode_cfg;
    phase_t              scan_phase;
    radix_t              scan_radix;
    bit                  digit_seen;
    logic [ValueW-1:0]   accum;
    int unsigned         parts_done;
    logic [ValueW-1:0]   part_store [PartsMax];
    bit                  error_seen;

    parse_result_t       pending_results[$];
    text_case_t          dir_cases[$];
    bit                  use_typed;
    parse_result_t       typed_res;
    int                  send_idle_pct;
    int                  stall_pct;
    bit                  hold_req;
    bit                  long_hold;
    int                  mismatch_count;
    int                  cycles;
    int                  bytes_sent;

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic void clear_scan();
        scan_phase = PH_START;
        scan_radix = RX_DEC;
        digit_seen = 1'b0;
        accum      = '0;
        parts_done = 0;
        error_seen = 1'b0;
    endfunction

    function automatic int radix_base(input radix_t rx);
        if (rx == RX_OCT)
            return 8;
        if (rx == RX_HEX)
            return 16;
        return 10;
    endfunction

    function automatic bit digit_value(input logic [CharW-1:0] c, input radix_t rx,
                                       output logic [4:0] d);
        d = '0;
        if (c >= CH_ZERO && c <= CH_NINE)
            d = 5'(c - CH_ZERO);
        else if (rx == RX_HEX && c >= CH_LO_A && c <= CH_LO_F)
            d = 5'(c - CH_LO_A + 8'd10);
        else if (rx == RX_HEX && c >= CH_UP_A && c <= CH_UP_F)
            d = 5'(c - CH_UP_A + 8'd10);
        else
            return 1'b0;
        return int'(d) < radix_base(rx);
    endfunction

    function automatic void close_part();
        if (!digit_seen || parts_done >= PartsMax)
        begin
            error_seen = 1'b1;
            return;
        end
        part_store[parts_done] = accum;
        parts_done++;
        scan_phase = PH_START;
        scan_radix = RX_DEC;
        digit_seen = 1'b0;
        accum      = '0;
    endfunction

    function automatic void scan_digit(input logic [CharW-1:0] c);
        logic [4:0]  d;
        logic [63:0] grown;
        if (digit_value(c, scan_radix, d))
        begin
            grown = 64'(accum) * 64'(radix_base(scan_radix)) + 64'(d);
            if (grown > 64'(ALL_ONES))
                error_seen = 1'b1;
            else
            begin
                accum      = grown[ValueW-1:0];
                digit_seen = 1'b1;
            end
        end
        else if (c == CH_DOT)
            close_part();
        else
            error_seen = 1'b1;
    endfunction

    // address mode: leading parts are bytes from the top, the last part fills the rest
    function automatic bit pack_value(output logic [ValueW-1:0] v);
        bit                last;
        logic [ValueW-1:0] lim;
        v = '0;
        if (parts_done < 1)
            return 1'b0;
        for (int i = 0; i < parts_done; i++)
        begin
            last = (i == parts_done - 1);
            if (mode_cfg || !last)
                lim = 32'hFF;
            else
                lim = ALL_ONES >> (8 * (parts_done - 1));
            if (part_store[i] > lim)
                return 1'b0;
            if (mode_cfg)
                v = (v << 8) | part_store[i];
            else if (last)
                v = v | part_store[i];
            else
                v = v | (part_store[i] << (8 * (3 - i)));
        end
        return 1'b1;
    endfunction

    function automatic bit scan_char(input logic [CharW-1:0] c, output parse_result_t res);
        logic [ValueW-1:0] v;
        res = FAIL_RES;
        if (c != CH_NUL)
        begin
            if (error_seen)
                return 1'b0;
            case (scan_phase)
                PH_START:
                begin
                    accum = '0;
                    if (c == CH_ZERO)
                    begin
                        scan_radix = RX_OCT;
                        digit_seen = 1'b1;
                        scan_phase = PH_ZERO;
                    end
                    else
                    begin
                        scan_radix = RX_DEC;
                        digit_seen = 1'b0;
                        scan_phase = PH_DIGITS;
                        scan_digit(c);
                    end
                end
                PH_ZERO:
                begin
                    scan_phase = PH_DIGITS;
                    if (c == CH_LO_X || c == CH_UP_X)
                    begin
                        scan_radix = RX_HEX;
                        digit_seen = 1'b0;
                    end
                    else
                    begin
                        scan_radix = RX_OCT;
                        scan_digit(c);
                    end
                end
                default:
                    scan_digit(c);
            endcase
            return 1'b0;
        end
        if (!error_seen)
        begin
            if (scan_phase == PH_START)
                error_seen = 1'b1;
            else
                close_part();
        end
        if (!error_seen && pack_value(v))
            res = '{ok: 1'b1, value: v, count: CountW'(parts_done)};
        clear_scan();
        return 1'b1;
    endfunction

    task automatic report_mismatch(input string msg);
        if (mismatch_count < PrintCap)
            $display("ERROR at cycle %0d: %s", cycles, msg);
        mismatch_count++;
    endtask

    task automatic add_case(input string t, input bit m, input bit typed, input logic ok,
                            input logic [ValueW-1:0] v, input logic [CountW-1:0] cnt);
        text_case_t tc;
        tc.text  = t;
        tc.mode  = m;
        tc.typed = typed;
        tc.res   = '{ok: ok, value: v, count: cnt};
        dir_cases.push_back(tc);
    endtask

    task automatic send_byte(input logic [CharW-1:0] c);
        parse_result_t res;
        bit            stalled;
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        char_byte <= c;
        do
        begin
            @(negedge clk);
            stalled = in_stall;
            @(posedge clk);
        end
        while (stalled);
        bytes_sent++;
        if (scan_char(c, res))
            pending_results.push_back(use_typed ? typed_res : res);
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_byte(s[i]);
        send_byte(CH_NUL);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DrainCycles) @(posedge clk);
    endtask

    task automatic write_mode(input bit m);
        result_mode_wr <= 1'b1;
        result_mode    <= m;
        @(posedge clk);
        result_mode_wr <= 1'b0;
        mode_cfg = m;
    endtask

    // mostly dotted addresses that fit the current mode, some wild values and flaws
    task automatic build_text(output string s);
        int              n;
        int              kind;
        int              flaw;
        longint unsigned v;
        longint unsigned lim;
        string           part;
        s = "";
        kind = $urandom_range(99);
        if (kind < 8)
        begin
            n = $urandom_range(8, 1);
            repeat (n)
            begin
                s = {s, "?"};
                s.putc(s.len() - 1, 8'($urandom_range(255, 1)));
            end
            return;
        end
        n = ($urandom_range(11) == 0) ? 5 : $urandom_range(4, 1);
        for (int i = 0; i < n; i++)
        begin
            if (i != 0)
                s = {s, "."};
            if (mode_cfg || i < n - 1)
                lim = 64'hFF;
            else
                lim = 64'hFFFF_FFFF >> (8 * (n - 1));
            if (kind < 75)
                v = ($urandom_range(3) == 0) ? lim : 64'($urandom_range(32'(lim)));
            else
            begin
                case ($urandom_range(2))
                    0: v = 64'($urandom);
                    1: v = 64'h1_0000_0000 + 64'($urandom_range(255));
                    default: v = 64'($urandom_range(4095));
                endcase
            end
            case ($urandom_range(2))
                0: part = $sformatf("%0d", v);
                1: part = $sformatf("0%0o", v);
                default:
                begin
                    part = $sformatf("0x%0h", v);
                    if ($urandom_range(1) != 0)
                        part = part.toupper();
                end
            endcase
            flaw = $urandom_range(79);
            if (flaw == 0)
                part = "";
            else if (flaw == 1)
                part = "0x";
            else if (flaw == 2)
                part = {"0", part, "9"};
            else if (flaw == 3)
            begin
                part = {part, "?"};
                part.putc(part.len() - 1, 8'($urandom_range(255, 1)));
            end
            s = {s, part};
        end
        if ($urandom_range(29) == 0)
            s = {s, "."};
    endtask

    // receiver side
    initial
    begin
        out_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            out_stall <= long_hold || (stall_pct != 0 && $urandom_range(99) < stall_pct);
        end
    end

    // long receiver hold-off, counted here
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                hold_req = 1'b0;
                long_hold <= 1'b1;
                repeat (HoldCycles) @(posedge clk);
                long_hold <= 1'b0;
            end
        end
    end

    // result beats are checked between edges, where everything is settled
    initial
    begin
        parse_result_t want;
        forever
        begin
            @(negedge clk);
            if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0)
            begin
                if (pending_results.size() == 0)
                    report_mismatch("result beat with nothing expected");
                else
                begin
                    want = pending_results.pop_front();
                    if (parse_ok !== want.ok)
                        report_mismatch($sformatf("parse_ok %0b, expected %0b",
                                                  parse_ok, want.ok));
                    if (address_value !== want.value)
                        report_mismatch($sformatf("address_value %h, expected %h",
                                                  address_value, want.value));
                    if (part_count !== want.count)
                        report_mismatch($sformatf("part_count %0d, expected %0d",
                                                  part_count, want.count));
                end
            end
        end
    end

    initial
    begin
        cycles = 0;
        while (cycles < CycleLimit)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("Some tests failed");
        $finish;
    end

    initial
    begin
        string text;
        int    start;
        bit    paused;
        rst_n          <= 1'b0;
        in_valid       <= 1'b0;
        char_byte      <= '0;
        result_mode_wr <= 1'b0;
        result_mode    <= 1'b0;
        send_idle_pct  = 0;
        stall_pct      = 0;
        mismatch_count = 0;
        bytes_sent     = 0;
        use_typed      = 1'b0;
        paused         = 1'b0;
        mode_cfg       = 1'b0;
        clear_scan();

        add_case("",                 0, 1, 1'b0, ALL_ONES,     3'd0);
        add_case("0",                0, 1, 1'b1, 32'h0,        3'd1);
        add_case("4294967295",       0, 1, 1'b1, ALL_ONES,     3'd1);
        add_case("0xFFFFFFFF",       0, 1, 1'b1, ALL_ONES,     3'd1);
        add_case("037777777777",     0, 1, 1'b1, ALL_ONES,     3'd1);
        add_case("4294967296",       0, 1, 1'b0, ALL_ONES,     3'd0);
        add_case("0x100000000",      0, 1, 1'b0, ALL_ONES,     3'd0);
        add_case("255.255.255.255",  0, 1, 1'b1, ALL_ONES,     3'd4);
        add_case("1.2.3.4.5",        0, 1, 1'b0, ALL_ONES,     3'd0);
        add_case("192.168.0x1.012",  0, 0, 1'b0, '0,           3'd0);
        add_case("10.0Xab.65535",    0, 0, 1'b0, '0,           3'd0);
        add_case("127.16777215",     0, 1, 1'b1, 32'h7FFFFFFF, 3'd2);
        add_case("1.16777216",       0, 1, 1'b0, ALL_ONES,     3'd0);
        add_case("1.2.65536",        0, 1, 1'b0, ALL_ONES,     3'd0);
        add_case("256.1.1.1",        0, 1, 1'b0, ALL_ONES,     3'd0);
        add_case("0x",               0, 1, 1'b0, ALL_ONES,     3'd0);
        add_case("0x.1",             0, 1, 1'b0, ALL_ONES,     3'd0);
        add_case("089",              0, 1, 1'b0, ALL_ONES,     3'd0);
        add_case(".1",               0, 1, 1'b0, ALL_ONES,     3'd0);
        add_case("1.",               0, 1, 1'b0, ALL_ONES,     3'd0);
        add_case("1..2",             0, 1, 1'b0, ALL_ONES,     3'd0);
        add_case("1.2a",             0, 1, 1'b0, ALL_ONES,     3'd0);
        add_case("\377\200",         0, 1, 1'b0, ALL_ONES,     3'd0);
        add_case("1.2.3.4",          1, 1, 1'b1, 32'h01020304, 3'd4);
        add_case("255",              1, 1, 1'b1, 32'hFF,       3'd1);
        add_case("0x10.010.9",       1, 0, 1'b0, '0,           3'd0);
        add_case("256",              1, 1, 1'b0, ALL_ONES,     3'd0);

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed rows, reset value of the mode register first
        foreach (dir_cases[i])
        begin
            if (dir_cases[i].mode != mode_cfg)
            begin
                wait_drained();
                write_mode(dir_cases[i].mode);
            end
            use_typed = dir_cases[i].typed;
            typed_res = dir_cases[i].res;
            send_text(dir_cases[i].text);
        end
        use_typed = 1'b0;

        for (int ph = 0; ph < 4; ph++)
        begin
            wait_drained();
            write_mode(ph % 2 == 0);
            case (ph)
                0:
                begin
                    send_idle_pct = 0;
                    stall_pct     = 0;
                end
                1:
                begin
                    send_idle_pct = 52;
                    stall_pct     = 0;
                end
                2:
                begin
                    send_idle_pct = 0;
                    stall_pct     = 52;
                    hold_req      = 1'b1;
                end
                default:
                begin
                    send_idle_pct = 28;
                    stall_pct     = 28;
                end
            endcase
            start = bytes_sent;
            while (bytes_sent - start < BytesPerPhase)
            begin
                build_text(text);
                send_text(text);
                // sender pauses once mid-run until every result is back
                if (ph == 1 && !paused && bytes_sent - start >= BytesPerPhase / 2)
                begin
                    wait_drained();
                    paused = 1'b1;
                end
            end
        end

        wait_drained();
        if (mismatch_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
